>>> sv/packed_fat12_table_engine_defines.svh
// Assertion macros shared by the FAT12 table engine RTL.
`ifndef PACKED_FAT12_TABLE_ENGINE_DEFINES_SVH
`define PACKED_FAT12_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define F12TE_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define F12TE_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> sv/f12te_pkg.sv
// Types and constants of the FAT12 table engine.
package f12te_pkg;

	localparam int OP_W        = 2;
	localparam int CLU_W       = 10;
	localparam int VAL_W       = 12;
	localparam int ROW_DW      = 24;
	localparam int FIELD_LIMIT = 1024;
	localparam int FAT12_LIMIT = 4085;

	localparam logic [7:0] NIB_LO_MASK = 8'h0F;
	localparam logic [7:0] NIB_HI_MASK = 8'hF0;

	typedef logic [VAL_W-1:0]  entry_t;
	typedef logic [CLU_W-1:0]  clu_t;
	// Three table bytes holding an even and an odd entry, byte 0 lowest
	typedef logic [ROW_DW-1:0] row_t;

	typedef enum logic [OP_W-1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_FIND  = 2'd2
	} op_t;

endpackage

>>> sv/f12te_row_unit.sv
// Entry extract and nibble-preserving merge on one three-byte table row.
module f12te_row_unit
	import f12te_pkg::*;
(
	input  row_t   row,
	input  logic   odd,
	input  entry_t new_value,
	output entry_t entry,
	output row_t   merged
);

	logic [7:0] b0, b1, b2;

	assign b0 = row[7:0];
	assign b1 = row[15:8];
	assign b2 = row[23:16];

	// Pick the low or high 12 bits of the byte pair
	always_comb begin
		if (odd) begin
			entry = {b2, b1[7:4]};
		end else begin
			entry = {b1[3:0], b0};
		end
	end

	// Rewrite the entry, keep the neighbor's nibble in the shared byte
	always_comb begin
		if (odd) begin
			merged = {new_value[11:4], (b1 & NIB_LO_MASK) | {new_value[3:0], 4'h0}, b0};
		end else begin
			merged = {b2, (b1 & NIB_HI_MASK) | {4'h0, new_value[11:8]}, new_value[7:0]};
		end
	end

endmodule

>>> sv/packed_fat12_table_engine.sv
// Top level of the FAT12 allocation table engine.
// Holds a FAT12 allocation table of ENTRY_COUNT packed 12-bit entries in one on-chip memory of
// three-byte rows (two entries per row). After reset a clearing pass writes every row to zero,
// during which s_axis_tready stays low. A read or a write passes through one registered memory
// read, then extract or merge-and-write in the shared row unit, then a hand-off to the output
// register. A find-free issues one memory read per cluster from cluster 2 upward and stops at
// the first free entry or at the last cluster below min(ENTRY_COUNT, 1024). The hand-off waits
// while the output register still holds a result that has not been taken. One request is in work
// at a time; a new one is taken while the previous result still waits in the output register.
`include "packed_fat12_table_engine_defines.svh"

module packed_fat12_table_engine
	import f12te_pkg::*;
#(
	parameter int ENTRY_COUNT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [9:0] cluster, [21:10] new_value, [23:22] zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // [11:0] entry_value, [21:12] free_cluster, [23:22] zero
);

	localparam int ROW_COUNT = (ENTRY_COUNT + 1) / 2;
	localparam int ROW_W     = $clog2(ROW_COUNT);
	localparam int LIM_A     = (ENTRY_COUNT < FAT12_LIMIT) ? ENTRY_COUNT : FAT12_LIMIT;
	localparam int SCAN_END  = (LIM_A < FIELD_LIMIT) ? LIM_A : FIELD_LIMIT;
	localparam int SCAN_W    = CLU_W + 1;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_ACCESS = 5'b00100,
		ST_SCAN   = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t              state_q;
	logic [OP_W-1:0]     op_q;
	clu_t                clu_q;
	entry_t              val_q;
	logic                in_range_q;
	logic [SCAN_W-1:0]   scan_q;
	logic [SCAN_W-1:0]   chk_q;
	logic                chk_vld_q;
	logic [ROW_W-1:0]    clr_q;
	entry_t              res_entry_q;
	clu_t                res_free_q;
	logic                m_valid_q;
	entry_t              m_entry_q;
	clu_t                m_free_q;

	row_t                mem_q [ROW_COUNT];
	row_t                rdata_q;
	logic                mem_re;
	logic [ROW_W-1:0]    mem_raddr;
	logic                mem_we;
	logic [ROW_W-1:0]    mem_waddr;
	row_t                mem_wdata;

	logic                accept;
	clu_t                in_cluster;
	logic                in_range;
	logic                odd_sel;
	entry_t              unit_entry;
	row_t                unit_merged;
	logic                scan_more;
	logic                out_free;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_cluster    = s_axis_tdata[CLU_W-1:0];
	assign in_range      = (in_cluster >= clu_t'(2)) && (int'(in_cluster) < ENTRY_COUNT);
	assign scan_more     = (scan_q < SCAN_W'(SCAN_END));
	assign out_free      = !m_valid_q || m_axis_tready;

	// Shared row unit: serves reads, writes and every scan step
	assign odd_sel = (state_q == ST_SCAN) ? chk_q[0] : clu_q[0];

	f12te_row_unit u_row (
		.row       (rdata_q),
		.odd       (odd_sel),
		.new_value (val_q),
		.entry     (unit_entry),
		.merged    (unit_merged)
	);

	// Select the read row: request cluster on accept, scan pointer while scanning
	always_comb begin
		if (state_q == ST_SCAN) begin
			mem_raddr = ROW_W'(scan_q[SCAN_W-1:1]);
			mem_re    = scan_more;
		end else begin
			mem_raddr = ROW_W'(in_cluster[CLU_W-1:1]);
			mem_re    = accept;
		end
	end

	// Select the write row: zero sweep after reset, merged row on a write
	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_waddr = clr_q;
			mem_wdata = '0;
			mem_we    = 1'b1;
		end else begin
			mem_waddr = ROW_W'(clu_q[CLU_W-1:1]);
			mem_wdata = unit_merged;
			mem_we    = (state_q == ST_ACCESS) && (op_q == OP_WRITE) && in_range_q;
		end
	end

	// Table memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_raddr];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			scan_q    <= '0;
			chk_vld_q <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			// Load the output register on hand-off, drop it once taken
			if ((state_q == ST_DONE) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ROW_W'(1);
					if (clr_q == ROW_W'(ROW_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						scan_q    <= SCAN_W'(2);
						chk_vld_q <= 1'b0;
						if (s_axis_tuser == OP_FIND) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_ACCESS;
						end
					end
				end
				ST_ACCESS: begin
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (chk_vld_q && ((unit_entry == '0) || (chk_q == SCAN_W'(SCAN_END - 1)))) begin
						state_q <= ST_DONE;
					end else if (scan_more) begin
						scan_q    <= scan_q + SCAN_W'(1);
						chk_vld_q <= 1'b1;
					end else begin
						chk_vld_q <= 1'b0;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request, scan and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= s_axis_tuser;
			clu_q      <= in_cluster;
			val_q      <= s_axis_tdata[CLU_W+VAL_W-1:CLU_W];
			in_range_q <= in_range;
		end
		if ((state_q == ST_SCAN) && scan_more) begin
			chk_q <= scan_q;
		end
		if (state_q == ST_ACCESS) begin
			res_entry_q <= ((op_q == OP_READ) && in_range_q) ? unit_entry : '0;
			res_free_q  <= '0;
		end
		if ((state_q == ST_SCAN) && chk_vld_q) begin
			res_entry_q <= '0;
			res_free_q  <= (unit_entry == '0) ? chk_q[CLU_W-1:0] : '0;
		end
		if ((state_q == ST_DONE) && out_free) begin
			m_entry_q <= res_entry_q;
			m_free_q  <= res_free_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, m_free_q, m_entry_q};

	// Checks
	`F12TE_ASSERT_IMP(a_free_bounds, m_axis_tvalid && (m_free_q != '0), (m_free_q >= clu_t'(2)) && (int'(m_free_q) < SCAN_END), "free cluster outside scan range")
	`F12TE_ASSERT_IMP(a_one_field, m_axis_tvalid, (m_entry_q == '0) || (m_free_q == '0), "entry and free cluster both set")
	`F12TE_ASSERT_IMP(a_we_state, mem_we, (state_q == ST_CLEAR) || (state_q == ST_ACCESS), "table written outside clear or access")
	`F12TE_ASSERT_NXT(a_busy_after_req, accept, !s_axis_tready, "ready stayed high after a request")

endmodule

>>> test/tb_packed_fat12_table_engine.sv
// Self-checking testbench of the FAT12 allocation table engine: directed rows, then random traffic.
module tb_packed_fat12_table_engine;
	import f12te_pkg::*;

	localparam int ENTRY_COUNT = 1024;
	localparam int TABLE_BYTES = (ENTRY_COUNT * 3 + 1) / 2;
	localparam int SCAN_CAP    = (FAT12_LIMIT < FIELD_LIMIT) ? FAT12_LIMIT : FIELD_LIMIT;
	localparam int SCAN_END    = (ENTRY_COUNT < SCAN_CAP) ? ENTRY_COUNT : SCAN_CAP;
	localparam int PHASE_ITEMS = 370;
	localparam int PHASES      = 4;
	localparam int SETTLE      = 50;
	localparam logic [1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		entry_t value;
		clu_t   free_c;
	} answer_t;

	typedef struct packed {
		logic [1:0] op;
		clu_t       clu;
		entry_t     val;
		logic       typed;
		entry_t     exp_val;
		clu_t       exp_free;
	} stim_row_t;

	// Typed answers only where they follow at a glance; other rows use the table mirror
	localparam int DIRECTED_ROWS = 25;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{OP_READ,  10'd2,    12'h000, 1'b1, 12'h000, 10'd0},
		'{OP_READ,  10'd1023, 12'h000, 1'b1, 12'h000, 10'd0},
		'{OP_FIND,  10'd0,    12'h000, 1'b1, 12'h000, 10'd2},
		'{OP_WRITE, 10'd0,    12'hFFF, 1'b1, 12'h000, 10'd0},
		'{OP_WRITE, 10'd1,    12'hFFF, 1'b1, 12'h000, 10'd0},
		'{OP_READ,  10'd0,    12'h000, 1'b1, 12'h000, 10'd0},
		'{OP_READ,  10'd1,    12'h000, 1'b1, 12'h000, 10'd0},
		'{OP_WRITE, 10'd2,    12'hABC, 1'b1, 12'h000, 10'd0},
		'{OP_WRITE, 10'd3,    12'h123, 1'b1, 12'h000, 10'd0},
		'{OP_READ,  10'd2,    12'h000, 1'b0, 12'h000, 10'd0},
		'{OP_READ,  10'd3,    12'h000, 1'b0, 12'h000, 10'd0},
		'{OP_WRITE, 10'd3,    12'hFFF, 1'b1, 12'h000, 10'd0},
		'{OP_READ,  10'd2,    12'h000, 1'b0, 12'h000, 10'd0},
		'{OP_WRITE, 10'd2,    12'h000, 1'b1, 12'h000, 10'd0},
		'{OP_READ,  10'd3,    12'h000, 1'b0, 12'h000, 10'd0},
		'{OP_FIND,  10'd1023, 12'hFFF, 1'b0, 12'h000, 10'd0},
		'{OP_WRITE, 10'd1023, 12'hFFF, 1'b1, 12'h000, 10'd0},
		'{OP_READ,  10'd1023, 12'h000, 1'b1, 12'hFFF, 10'd0},
		'{OP_WRITE, 10'd1022, 12'h800, 1'b1, 12'h000, 10'd0},
		'{OP_READ,  10'd1022, 12'h000, 1'b0, 12'h000, 10'd0},
		'{OP_READ,  10'd1023, 12'h000, 1'b0, 12'h000, 10'd0},
		'{OP_SPARE, 10'd1023, 12'hFFF, 1'b1, 12'h000, 10'd0},
		'{OP_SPARE, 10'd5,    12'h000, 1'b1, 12'h000, 10'd0},
		'{OP_FIND,  10'd0,    12'h000, 1'b0, 12'h000, 10'd0},
		'{OP_READ,  10'h155,  12'h000, 1'b0, 12'h000, 10'd0}
	};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // [9:0] cluster, [21:10] new_value, [23:22] zero
	logic [1:0]  s_axis_tuser;   // [1:0] operation
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // [11:0] entry_value, [21:12] free_cluster, [23:22] zero

	logic [7:0] fat_bytes [TABLE_BYTES];
	answer_t    pending_answers [$];
	int         error_count;
	int         src_idle_pct;
	int         sink_stall_pct;

	packed_fat12_table_engine #(
		.ENTRY_COUNT(ENTRY_COUNT)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Read one packed entry from the mirrored byte store
	function automatic entry_t fat_entry(input int unsigned c);
		int unsigned pos;
		logic [7:0]  lo;
		logic [7:0]  hi;
		if (c < 2 || c >= ENTRY_COUNT)
			return '0;
		pos = (c * 3) >> 1;
		lo  = fat_bytes[pos];
		hi  = (pos + 1 < TABLE_BYTES) ? fat_bytes[pos + 1] : 8'h00;
		if (c[0])
			return {hi, lo[7:4]};
		return {hi[3:0] & NIB_LO_MASK[3:0], lo};
	endfunction

	// Merge a 12-bit entry into its byte pair, keeping the neighbor's nibble
	function automatic void fat_store(input int unsigned c, input entry_t v);
		int unsigned pos;
		if (c < 2 || c >= ENTRY_COUNT)
			return;
		pos = (c * 3) >> 1;
		if (c[0]) begin
			fat_bytes[pos] = (fat_bytes[pos] & NIB_LO_MASK) | {v[3:0], 4'h0};
			if (pos + 1 < TABLE_BYTES)
				fat_bytes[pos + 1] = v[11:4];
		end else begin
			fat_bytes[pos] = v[7:0];
			if (pos + 1 < TABLE_BYTES)
				fat_bytes[pos + 1] = (fat_bytes[pos + 1] & NIB_HI_MASK) | {4'h0, v[11:8]};
		end
	endfunction

	function automatic clu_t fat_first_free();
		for (int c = 2; c < SCAN_END; c++) begin
			if (fat_entry(c) == '0)
				return clu_t'(c);
		end
		return '0;
	endfunction

	// Apply one request to the mirror and return the answer it should produce
	function automatic answer_t fat_apply(input logic [1:0] op, input clu_t clu, input entry_t val);
		answer_t ans;
		ans = '0;
		if (op == OP_READ)
			ans.value = fat_entry(clu);
		else if (op == OP_WRITE)
			fat_store(clu, val);
		else if (op == OP_FIND)
			ans.free_c = fat_first_free();
		return ans;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
		error_count++;
	endtask

	// Offer one request and record its answer once accepted; returns at a falling edge
	task automatic send_request(input logic [1:0] op, input clu_t clu, input entry_t val,
			input logic typed, input answer_t typed_answer);
		answer_t ans;
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, val, clu};
		s_axis_tuser  <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		ans = fat_apply(op, clu, val);
		pending_answers.push_back(typed ? typed_answer : ans);
		@(negedge clk);
	endtask

	// Mostly fill the lowest free cluster so finds walk deep and the table fills up
	task automatic pick_request(output logic [1:0] op, output clu_t clu, output entry_t val);
		int   roll;
		clu_t hole;
		roll = $urandom_range(99);
		op   = OP_WRITE;
		clu  = clu_t'($urandom_range(1023));
		val  = entry_t'($urandom_range(4095, 1));
		if (roll < 66) begin
			hole = fat_first_free();
			if (hole != '0)
				clu = hole;
		end else if (roll < 74) begin
			if ($urandom_range(3) == 0)
				val = '0;
			else
				val = entry_t'($urandom_range(4095));
		end else if (roll < 86) begin
			op = OP_READ;
			val = entry_t'($urandom_range(4095));
		end else if (roll < 94) begin
			op = OP_FIND;
			val = entry_t'($urandom_range(4095));
		end else if (roll < 97) begin
			clu = clu_t'($urandom_range(1));
			val = entry_t'($urandom_range(4095));
		end else begin
			op = OP_SPARE;
			val = entry_t'($urandom_range(4095));
		end
	endtask

	// Stall the result side at random
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Compare each accepted result with the oldest pending answer
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("result with no request pending", m_axis_tdata, 0);
			end else begin
				want = pending_answers.pop_front();
				if (m_axis_tdata[11:0] !== want.value)
					report_mismatch("entry_value", m_axis_tdata[11:0], want.value);
				if (m_axis_tdata[21:12] !== want.free_c)
					report_mismatch("free_cluster", m_axis_tdata[21:12], want.free_c);
				if (m_axis_tdata[23:22] !== 2'b00)
					report_mismatch("tdata padding", m_axis_tdata[23:22], 0);
			end
		end
	end

	initial begin
		#100_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [1:0] op;
		clu_t       clu;
		entry_t     val;
		error_count    = 0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tuser   = '0;
		m_axis_tready  = 1'b0;
		for (int i = 0; i < TABLE_BYTES; i++)
			fat_bytes[i] = 8'h00;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows, no idling
		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_request(DIRECTED[i].op, DIRECTED[i].clu, DIRECTED[i].val, DIRECTED[i].typed,
				'{value: DIRECTED[i].exp_val, free_c: DIRECTED[i].exp_free});
		s_axis_tvalid <= 1'b0;
		while (pending_answers.size() != 0)
			@(negedge clk);

		// Random traffic under each idling mix; drain between phases
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					src_idle_pct   = 0;
					sink_stall_pct = 0;
				end
				1: begin
					src_idle_pct   = 85;
					sink_stall_pct = 0;
				end
				2: begin
					src_idle_pct   = 0;
					sink_stall_pct = 85;
				end
				default: begin
					src_idle_pct   = 19;
					sink_stall_pct = 19;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick_request(op, clu, val);
				send_request(op, clu, val, 1'b0, '0);
			end
			s_axis_tvalid <= 1'b0;
			while (pending_answers.size() != 0)
				@(negedge clk);
		end

		repeat (SETTLE) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/f12te_pkg.sv
sv/f12te_row_unit.sv
sv/packed_fat12_table_engine.sv
test/tb_packed_fat12_table_engine.sv
